// ===== src/cwf_pkg.sv =====
// ----------------------------------------------------------------------------
// cwf_pkg
// Shared codes, reset values and controller/datapath interface types for the
// carrot waypoint follower.
// ----------------------------------------------------------------------------
`default_nettype none

package cwf_pkg;

    // input operations
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result events
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_PASSED = 2'd1;
    localparam logic [1:0] EV_DONE   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP   = 3'd0;
    localparam logic [2:0] CFG_LEAD   = 3'd1;
    localparam logic [2:0] CFG_REACH  = 3'd2;
    localparam logic [2:0] CFG_TMO    = 3'd3;
    localparam logic [2:0] CFG_GROUND = 3'd4;
    localparam logic [2:0] CFG_TOTAL  = 3'd5;

    localparam logic [30:0] STEP_RST  = 31'd3277;
    localparam logic [30:0] LEAD_RST  = 31'd131072;
    localparam logic [30:0] REACH_RST = 31'd19661;
    localparam logic [31:0] TMO_RST   = 32'd30000;

    // length phases of a tick
    localparam logic [1:0] PH_STEP = 2'd0;   // carrot to waypoint
    localparam logic [1:0] PH_LEAD = 2'd1;   // drone to carrot
    localparam logic [1:0] PH_DIST = 2'd2;   // waypoint to drone

    // datapath commands
    localparam logic [3:0] DP_NOP      = 4'd0;
    localparam logic [3:0] DP_WRITE    = 4'd1;
    localparam logic [3:0] DP_START    = 4'd2;
    localparam logic [3:0] DP_LATCH_W  = 4'd3;
    localparam logic [3:0] DP_VEC      = 4'd4;
    localparam logic [3:0] DP_SQ_MUL   = 4'd5;
    localparam logic [3:0] DP_SQ_ACC   = 4'd6;
    localparam logic [3:0] DP_SQRT_GO  = 4'd7;
    localparam logic [3:0] DP_SNAP     = 4'd8;
    localparam logic [3:0] DP_SC_MUL   = 4'd9;
    localparam logic [3:0] DP_DIV_GO   = 4'd10;
    localparam logic [3:0] DP_SC_STORE = 4'd11;
    localparam logic [3:0] DP_OUT      = 4'd12;
    localparam logic [3:0] DP_OUT_NONE = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] axis;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       no_active;
        logic       snap;
        logic       clamp;
        logic       sqrt_done;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/cwf_sqrt.sv =====
// ----------------------------------------------------------------------------
// cwf_sqrt
// Restoring square root, one result bit per cycle: floor(sqrt) of a 66-bit
// radicand; done pulses for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_sqrt import cwf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [65:0] radicand,
    output logic      [32:0] root,
    output logic             done
);

    localparam int ITER = 33;

    logic [65:0] rad_reg;
    logic [34:0] rem_reg;
    logic [32:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [36:0] rem_sh;
    logic [36:0] trial;
    logic [36:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, rad_reg[65:64]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder stays below twice the partial root, so 35 bits hold it
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[63:0], 2'b00};
            rem_reg  <= ge ? diff[34:0] : rem_sh[34:0];
            root_reg <= {root_reg[31:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/cwf_div.sv =====
// ----------------------------------------------------------------------------
// cwf_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// 32 bits (dividend below divisor * 2^32).
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_div import cwf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [62:0] dividend,
    input  wire logic [33:0] divisor,
    output logic      [31:0] quotient,
    output logic             done
);

    localparam int ITER = 32;

    logic [33:0] rem_reg;
    logic [31:0] low_reg;
    logic [33:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [34:0] rem_sh;
    logic [34:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, low_reg[31]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // quotient bits shift into the low word as dividend bits leave it
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {3'b000, dividend[62:32]};
            low_reg <= dividend[31:0];
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[33:0] : rem_sh[33:0];
            low_reg <= {low_reg[30:0], ge};
        end
    end

    assign quotient = low_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== src/cwf_datapath.sv =====
// ----------------------------------------------------------------------------
// cwf_datapath
// Configuration registers, waypoint table, carrot state, shared multiplier,
// square root and divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_datapath import cwf_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic               cfg_valid,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [31:0] cfg_data,
    input  wire logic               in_accept,
    input  wire logic        [1:0]  operation,
    input  wire logic        [5:0]  slot,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    input  wire logic        [31:0] elapsed_ms,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic signed      [31:0] carrot_x,
    output logic signed      [31:0] carrot_y,
    output logic signed      [31:0] carrot_z,
    output logic signed      [15:0] orient_x,
    output logic signed      [15:0] orient_y,
    output logic signed      [15:0] orient_z,
    output logic signed      [15:0] orient_w,
    output logic             [31:0] drone_distance,
    output logic             [5:0]  active_index,
    output logic             [1:0]  event_res,
    output logic                    tmo_event
);

    localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;

    // configuration
    logic        [30:0] step_reg;
    logic        [30:0] lead_reg;
    logic        [30:0] reach_reg;
    logic        [31:0] tmo_reg;
    logic signed [31:0] ground_reg;
    logic        [6:0]  total_reg;

    // latched input item
    logic        [1:0]  op_reg;
    logic        [5:0]  slot_reg;
    logic signed [31:0] pos_reg [3];
    logic        [63:0] quat_reg;
    logic        [31:0] el_reg;

    // guidance state
    logic signed [31:0] carrot_reg [3];
    logic        [6:0]  cur_reg;
    logic               snap_reg;

    // table: {quat, z, y, x}
    logic [159:0] mem [WAYPOINT_DEPTH];
    logic [159:0] rd_reg;

    logic signed [31:0] w_reg [3];
    logic signed [32:0] vec_reg [3];
    logic        [63:0] prod_reg;
    logic        [65:0] acc_reg;

    logic               out_valid_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic        [63:0] orient_reg;
    logic        [31:0] dist_reg;
    logic        [5:0]  idx_reg;
    logic        [1:0]  ev_reg;
    logic               bt_reg;

    // combinational
    logic        [6:0]  total_eff;
    logic signed [32:0] vsel;
    logic        [32:0] vneg;
    logic        [31:0] vmag;
    logic        [31:0] mul_b;
    logic        [63:0] product;
    logic        [32:0] root;
    logic               sqrt_done;
    logic        [31:0] quo;
    logic               div_done;
    logic signed [32:0] zsum;
    logic signed [31:0] wz;
    logic signed [33:0] base;
    logic signed [33:0] delta;
    logic signed [33:0] moved;
    logic               timed_out;
    logic               last_wp;
    logic               near;
    logic        [1:0]  ev;
    logic               advance;

    assign total_eff = (32'(total_reg) > WAYPOINT_DEPTH) ? 7'(WAYPOINT_DEPTH) : total_reg;

    assign vsel    = vec_reg[cmd.axis];
    assign vneg    = -vsel;
    assign vmag    = vsel[32] ? vneg[31:0] : vsel[31:0];
    assign mul_b   = (cmd.op == DP_SQ_MUL) ? vmag
                   : {1'b0, (cmd.phase == PH_LEAD) ? lead_reg : step_reg};
    assign product = vmag * mul_b;

    assign zsum = {ground_reg[31], ground_reg} + {rd_reg[95], rd_reg[95:64]};
    assign wz   = (zsum[32] != zsum[31]) ? (zsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                         : zsum[31:0];

    // move one axis: carrot plus step, or drone plus clamped lead
    assign base  = (cmd.phase == PH_LEAD) ? 34'(pos_reg[cmd.axis]) : 34'(carrot_reg[cmd.axis]);
    assign delta = vsel[32] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    assign moved = base + delta;

    assign timed_out = el_reg > tmo_reg;
    assign last_wp   = ({1'b0, cur_reg} + 8'd1) >= {1'b0, total_eff};
    assign near      = root < {2'b00, reach_reg};

    always_comb
    begin
        ev      = EV_NONE;
        advance = 1'b0;
        if (last_wp)
        begin
            if (near || timed_out)
                ev = EV_DONE;
        end
        else if (snap_reg || timed_out)
        begin
            ev      = EV_PASSED;
            advance = 1'b1;
        end
    end

    cwf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == DP_SQRT_GO),
        .radicand (acc_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    cwf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == DP_DIV_GO),
        .dividend (prod_reg[62:0]),
        .divisor  ({1'b0, root}),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb
    begin
        sts.op        = op_reg;
        sts.no_active = cur_reg >= total_eff;
        sts.snap      = root <= {2'b00, step_reg};
        sts.clamp     = root > {2'b00, lead_reg};
        sts.sqrt_done = sqrt_done;
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // control and guidance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RST;
            lead_reg      <= LEAD_RST;
            reach_reg     <= REACH_RST;
            tmo_reg       <= TMO_RST;
            ground_reg    <= '0;
            total_reg     <= '0;
            for (int i = 0; i < 3; i++)
                carrot_reg[i] <= '0;
            cur_reg       <= '0;
            snap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_STEP:   step_reg   <= cfg_data[30:0];
                    CFG_LEAD:   lead_reg   <= cfg_data[30:0];
                    CFG_REACH:  reach_reg  <= cfg_data[30:0];
                    CFG_TMO:    tmo_reg    <= cfg_data;
                    CFG_GROUND: ground_reg <= cfg_data;
                    CFG_TOTAL:  total_reg  <= cfg_data[6:0];
                    default:    ;
                endcase
            end

            case (cmd.op)
                DP_START:
                begin
                    for (int i = 0; i < 3; i++)
                        carrot_reg[i] <= pos_reg[i];
                    cur_reg <= '0;
                end
                DP_LATCH_W:  snap_reg <= 1'b0;
                DP_SNAP:
                begin
                    for (int i = 0; i < 3; i++)
                        carrot_reg[i] <= w_reg[i];
                    snap_reg <= 1'b1;
                end
                DP_SC_STORE: carrot_reg[cmd.axis] <= moved[31:0];
                DP_OUT:
                begin
                    if (advance)
                        cur_reg <= cur_reg + 7'd1;
                end
                default: ;
            endcase

            if (cmd.op == DP_OUT || cmd.op == DP_OUT_NONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= operation;
            slot_reg   <= slot;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            quat_reg   <= {quat_w, quat_z, quat_y, quat_x};
            el_reg     <= elapsed_ms;
        end

        case (cmd.op)
            DP_LATCH_W:
            begin
                w_reg[0] <= rd_reg[31:0];
                w_reg[1] <= rd_reg[63:32];
                w_reg[2] <= wz;
            end
            DP_VEC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    case (cmd.phase)
                        PH_STEP: vec_reg[i] <= 33'(w_reg[i]) - 33'(carrot_reg[i]);
                        PH_LEAD: vec_reg[i] <= 33'(carrot_reg[i]) - 33'(pos_reg[i]);
                        default: vec_reg[i] <= 33'(pos_reg[i]) - 33'(w_reg[i]);
                    endcase
                end
                acc_reg <= '0;
            end
            DP_SQ_MUL:  prod_reg <= product;
            DP_SC_MUL:  prod_reg <= product;
            DP_SQ_ACC:  acc_reg  <= acc_reg + {2'b00, prod_reg};
            DP_OUT:
            begin
                cx_reg     <= carrot_reg[0];
                cy_reg     <= carrot_reg[1];
                cz_reg     <= carrot_reg[2];
                orient_reg <= rd_reg[159:96];
                dist_reg   <= root[32] ? '1 : root[31:0];
                idx_reg    <= cur_reg[5:0];
                ev_reg     <= ev;
                bt_reg     <= (ev != EV_NONE) && timed_out;
            end
            DP_OUT_NONE:
            begin
                cx_reg     <= '0;
                cy_reg     <= '0;
                cz_reg     <= '0;
                orient_reg <= '0;
                dist_reg   <= '0;
                idx_reg    <= (total_eff == 7'd0) ? 6'd0 : 6'(total_eff - 7'd1);
                ev_reg     <= EV_DONE;
                bt_reg     <= 1'b0;
            end
            default: ;
        endcase
    end

    // waypoint table, registered read at the active index
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_WRITE && 32'(slot_reg) < WAYPOINT_DEPTH)
            mem[AW'(slot_reg)] <= {quat_reg, pos_reg[2], pos_reg[1], pos_reg[0]};
        rd_reg <= mem[AW'(cur_reg)];
    end

    assign out_valid      = out_valid_reg;
    assign carrot_x       = cx_reg;
    assign carrot_y       = cy_reg;
    assign carrot_z       = cz_reg;
    assign orient_x       = orient_reg[15:0];
    assign orient_y       = orient_reg[31:16];
    assign orient_z       = orient_reg[47:32];
    assign orient_w       = orient_reg[63:48];
    assign drone_distance = dist_reg;
    assign active_index   = idx_reg;
    assign event_res      = ev_reg;
    assign tmo_event      = bt_reg;

endmodule

`default_nettype wire

// ===== src/cwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cwf_ctrl
// Sequencer for one item: decode, three length passes (carrot step, lead
// clamp, drone distance), per-axis scaling, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cwf_ctrl import cwf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_accept,
    output logic      in_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_VEC      = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_ACC      = 4'd4;
    localparam logic [3:0] S_SQGO     = 4'd5;
    localparam logic [3:0] S_SQWAIT   = 4'd6;
    localparam logic [3:0] S_DECIDE   = 4'd7;
    localparam logic [3:0] S_SCMUL    = 4'd8;
    localparam logic [3:0] S_DIVGO    = 4'd9;
    localparam logic [3:0] S_DIVWAIT  = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;
    localparam logic [3:0] S_OUT_NONE = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        cmd.op     = DP_NOP;
        cmd.axis   = axis_reg;
        cmd.phase  = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (sts.op)
                    OP_LOAD:  cmd.op = DP_WRITE;
                    OP_START: cmd.op = DP_START;
                    OP_TICK:
                    begin
                        if (sts.no_active)
                            state_next = S_OUT_NONE;
                        else
                        begin
                            cmd.op     = DP_LATCH_W;
                            phase_next = PH_STEP;
                            state_next = S_VEC;
                        end
                    end
                    default: ;
                endcase
            end
            S_VEC:
            begin
                cmd.op     = DP_VEC;
                axis_next  = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = DP_SQ_MUL;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = DP_SQ_ACC;
                if (axis_reg == 2'd2)
                    state_next = S_SQGO;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_SQGO:
            begin
                cmd.op     = DP_SQRT_GO;
                state_next = S_SQWAIT;
            end
            S_SQWAIT:
            begin
                if (sts.sqrt_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                axis_next = 2'd0;
                case (phase_reg)
                    PH_STEP:
                    begin
                        if (sts.snap)
                        begin
                            cmd.op     = DP_SNAP;
                            phase_next = PH_LEAD;
                            state_next = S_VEC;
                        end
                        else
                            state_next = S_SCMUL;
                    end
                    PH_LEAD:
                    begin
                        if (sts.clamp)
                            state_next = S_SCMUL;
                        else
                        begin
                            phase_next = PH_DIST;
                            state_next = S_VEC;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_SCMUL:
            begin
                cmd.op     = DP_SC_MUL;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.op     = DP_DIV_GO;
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.op = DP_SC_STORE;
                    if (axis_reg == 2'd2)
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = S_VEC;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SCMUL;
                    end
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            S_OUT_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_OUT_NONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_STEP;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

`default_nettype wire

// ===== src/carrot_waypoint_follower.sv =====
// ----------------------------------------------------------------------------
// carrot_waypoint_follower
// Carrot-chasing waypoint guidance: waypoint table, mission start and tick.
// ----------------------------------------------------------------------------
// A tick with an active waypoint makes three length passes on the shared
// square root, plus up to six axis scalings on the divider when the carrot
// is stepped and clamped. One item is worked at a time; a finished result
// waits in the output register while the next item is taken. Reset clears
// the carrot and index and restores the configuration; the table is
// undefined.
`default_nettype none

module carrot_waypoint_follower import cwf_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [31:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic        [1:0]  operation,
    input  wire logic        [5:0]  slot,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    input  wire logic        [31:0] elapsed_ms,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed      [31:0] carrot_x,
    output logic signed      [31:0] carrot_y,
    output logic signed      [31:0] carrot_z,
    output logic signed      [15:0] orient_x,
    output logic signed      [15:0] orient_y,
    output logic signed      [15:0] orient_z,
    output logic signed      [15:0] orient_w,
    output logic             [31:0] drone_distance,
    output logic             [5:0]  active_index,
    output logic             [1:0]  event_res,
    output logic                    tmo_event
);

    cmd_t cmd;
    sts_t sts;
    logic in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;

    cwf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    cwf_datapath #(
        .WAYPOINT_DEPTH (WAYPOINT_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_accept      (in_accept),
        .operation      (operation),
        .slot           (slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .quat_x         (quat_x),
        .quat_y         (quat_y),
        .quat_z         (quat_z),
        .quat_w         (quat_w),
        .elapsed_ms     (elapsed_ms),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .carrot_x       (carrot_x),
        .carrot_y       (carrot_y),
        .carrot_z       (carrot_z),
        .orient_x       (orient_x),
        .orient_y       (orient_y),
        .orient_z       (orient_z),
        .orient_w       (orient_w),
        .drone_distance (drone_distance),
        .active_index   (active_index),
        .event_res      (event_res),
        .tmo_event      (tmo_event)
    );

endmodule

`default_nettype wire
